[rtl/tlpt_pkg.sv]
// Shared types and constants for the two-level page table manager.
`default_nettype none

package tlpt_pkg;

    localparam int ENTRIES_PER_TABLE = 1024;
    localparam int DIR_ENTRIES       = 1024;
    localparam int IDX_W             = 10;
    localparam int DIR_AW            = 10;

    localparam logic [1:0] CMD_MAP   = 2'd0;
    localparam logic [1:0] CMD_UNMAP = 2'd1;
    localparam logic [1:0] CMD_XLATE = 2'd2;

    localparam logic [1:0] STS_DONE     = 2'd0;
    localparam logic [1:0] STS_UNMAPPED = 2'd1;
    localparam logic [1:0] STS_NO_TABLE = 2'd2;

    localparam logic [31:0] FRAME_MASK  = 32'hFFFF_F000;
    localparam logic [31:0] PRESENT_BIT = 32'h0000_0001;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] virt_addr;
        logic [31:0] phys_addr;
        logic [11:0] page_flags;
    } req_t;

    typedef struct packed {
        logic [31:0] result_addr;
        logic [1:0]  status;
    } rsp_t;

endpackage

`default_nettype wire

[rtl/two_level_page_table_manager.sv]
// Two-level page table manager: map, unmap and translate over a directory RAM and a table RAM.
//
// Each transaction reads the directory entry selected by virt_addr[31:22] and then writes or
// reads the table entry selected by virt_addr[21:12] in the table RAM. Map and unmap finish
// after the directory read, translate also needs the table read; one transaction is in flight
// at a time, and a finished result may wait in the output register while the next request is
// taken. Map hands out pool tables in order and never reclaims them; with the pool exhausted a
// map to a new 4 MiB region returns status 2. After reset the block runs a clearing pass over
// both RAMs and holds req_stall high until every table RAM entry is cleared, before it takes
// its first request.
`default_nettype none

module two_level_page_table_manager #(
    parameter int POOL_TABLES = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire tlpt_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output tlpt_pkg::rsp_t     rsp
);

    import tlpt_pkg::*;

    localparam int IW        = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
    localparam int CW        = $clog2(POOL_TABLES + 1);
    localparam int TBL_DEPTH = POOL_TABLES * ENTRIES_PER_TABLE;
    localparam int TAW       = $clog2(TBL_DEPTH);
    localparam int DW        = IW + 1;

    localparam logic [TAW-1:0] CLR_LAST = TAW'(TBL_DEPTH - 1);
    localparam logic [CW-1:0]  POOL_CNT = CW'(POOL_TABLES);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DIR,
        S_TBL
    } state_t;

    state_t         state_reg, state_next;
    logic [TAW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0]  in_use_reg, in_use_next;
    logic           rsp_valid_reg, rsp_valid_next;
    rsp_t           rsp_reg, rsp_next;
    req_t           req_q_reg, req_q_next;

    logic              dir_we, dir_re;
    logic [DIR_AW-1:0] dir_waddr, dir_raddr;
    logic [DW-1:0]     dir_wdata, dir_rdata;
    logic              tbl_we, tbl_re;
    logic [TAW-1:0]    tbl_waddr, tbl_raddr;
    logic [31:0]       tbl_wdata, tbl_rdata;

    logic           out_free;
    logic           dir_present;
    logic [IW-1:0]  dir_tidx;
    logic [IW-1:0]  sel_tidx;
    logic [IDX_W-1:0] tbl_idx;
    logic [TAW-1:0] tbl_addr;
    logic [31:0]    new_entry;
    logic           pool_full;

    tlpt_ram #(
        .WIDTH (DW),
        .DEPTH (DIR_ENTRIES)
    ) u_dir_ram (
        .clk   (clk),
        .we    (dir_we),
        .waddr (dir_waddr),
        .wdata (dir_wdata),
        .re    (dir_re),
        .raddr (dir_raddr),
        .rdata (dir_rdata)
    );

    tlpt_ram #(
        .WIDTH (32),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    assign out_free    = !rsp_valid_reg || !rsp_stall;
    assign dir_present = dir_rdata[IW];
    assign dir_tidx    = dir_rdata[IW-1:0];
    assign pool_full   = (in_use_reg == POOL_CNT);
    assign sel_tidx    = dir_present ? dir_tidx : IW'(in_use_reg);
    assign tbl_idx     = req_q_reg.virt_addr[21:12];
    assign tbl_addr    = TAW'({sel_tidx, tbl_idx});
    assign new_entry   = (req_q_reg.phys_addr & FRAME_MASK)
                       | {20'd0, req_q_reg.page_flags} | PRESENT_BIT;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        in_use_next    = in_use_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        req_q_next     = req_q_reg;

        dir_we    = 1'b0;
        dir_waddr = req_q_reg.virt_addr[31:22];
        dir_wdata = {1'b1, IW'(in_use_reg)};
        dir_re    = 1'b0;
        dir_raddr = req.virt_addr[31:22];
        tbl_we    = 1'b0;
        tbl_waddr = tbl_addr;
        tbl_wdata = new_entry;
        tbl_re    = 1'b0;
        tbl_raddr = tbl_addr;

        unique case (state_reg)
            S_CLEAR:
            begin
                dir_we    = 1'b1;
                dir_waddr = clr_cnt_reg[DIR_AW-1:0];
                dir_wdata = '0;
                tbl_we    = 1'b1;
                tbl_waddr = clr_cnt_reg;
                tbl_wdata = '0;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + TAW'(1);
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_q_next = req;
                    dir_re     = 1'b1;
                    state_next = S_DIR;
                end
            end
            S_DIR:
            begin
                if (out_free)
                begin
                    rsp_next       = '{result_addr: 32'd0, status: STS_DONE};
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    unique case (req_q_reg.command)
                        CMD_MAP:
                        begin
                            if (!dir_present && pool_full)
                            begin
                                rsp_next.status = STS_NO_TABLE;
                            end
                            else
                            begin
                                if (!dir_present)
                                begin
                                    dir_we      = 1'b1;
                                    in_use_next = in_use_reg + CW'(1);
                                end
                                tbl_we = 1'b1;
                            end
                        end
                        CMD_UNMAP:
                        begin
                            tbl_we    = dir_present;
                            tbl_wdata = '0;
                        end
                        CMD_XLATE:
                        begin
                            if (dir_present)
                            begin
                                tbl_re         = 1'b1;
                                rsp_valid_next = 1'b0;
                                state_next     = S_TBL;
                            end
                            else
                            begin
                                rsp_next.status = STS_UNMAPPED;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_TBL:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (tbl_rdata[0])
                    begin
                        rsp_next.result_addr = (tbl_rdata & FRAME_MASK)
                                             | {20'd0, req_q_reg.virt_addr[11:0]};
                        rsp_next.status      = STS_DONE;
                    end
                    else
                    begin
                        rsp_next.result_addr = 32'd0;
                        rsp_next.status      = STS_UNMAPPED;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            in_use_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            in_use_reg    <= in_use_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg   <= rsp_next;
        req_q_reg <= req_q_next;
    end

endmodule

`default_nettype wire

[rtl/tlpt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tlpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sim/two_level_page_table_manager_tb.sv]
// Testbench for the two-level page table manager: directed and random traffic against a behavioral page walk.
module two_level_page_table_manager_tb;
    import tlpt_pkg::*;

    localparam int POOL       = 16;
    localparam int LIMIT      = 400000;
    localparam int N_RANDOM   = 1400;
    localparam int DRAIN      = 20;
    localparam int HOLD_AFTER = 400;
    localparam int HOLD_LEN   = 300;
    localparam logic [1:0] CMD_NOP = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    two_level_page_table_manager #(.POOL_TABLES(POOL)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always #5 clk = ~clk;

    // page walk state
    bit          region_live [DIR_ENTRIES];
    int          region_table[DIR_ENTRIES];
    bit [31:0]   pte_mem     [POOL * ENTRIES_PER_TABLE];
    int          tables_taken = 0;

    req_t        req_backlog[$];
    rsp_t        walk_results[$];

    logic        req_fire = 1'b0;
    int          req_gap = 0;
    int          req_calm = 0;
    int          req_count = 0;
    int          rsp_count = 0;
    int          item_total = 0;
    int          stall_left = 0;
    int          free_left = 0;
    logic        hold_rsp = 1'b0;
    int          fail_count = 0;
    int          cycle_cnt = 0;

    function automatic rsp_t page_walk(req_t r);
        rsp_t        o;
        logic [9:0]  dir;
        logic [9:0]  ti;
        int          slot;
        o.result_addr = '0;
        o.status = STS_DONE;
        dir = r.virt_addr[31:22];
        ti = r.virt_addr[21:12];
        case (r.command)
            CMD_MAP:
            begin
                if (!region_live[dir])
                begin
                    if (tables_taken >= POOL)
                        o.status = STS_NO_TABLE;
                    else
                    begin
                        for (int i = 0; i < ENTRIES_PER_TABLE; i++)
                            pte_mem[tables_taken * ENTRIES_PER_TABLE + i] = '0;
                        region_table[dir] = tables_taken;
                        region_live[dir] = 1'b1;
                        tables_taken++;
                    end
                end
                if (o.status == STS_DONE)
                begin
                    slot = region_table[dir] * ENTRIES_PER_TABLE + ti;
                    pte_mem[slot] = (r.phys_addr & FRAME_MASK) | {20'd0, r.page_flags}
                                    | PRESENT_BIT;
                end
            end
            CMD_UNMAP:
            begin
                if (region_live[dir])
                    pte_mem[region_table[dir] * ENTRIES_PER_TABLE + ti] = '0;
            end
            CMD_XLATE:
            begin
                slot = region_table[dir] * ENTRIES_PER_TABLE + ti;
                if (region_live[dir] && (pte_mem[slot] & PRESENT_BIT) != 0)
                    o.result_addr = (pte_mem[slot] & FRAME_MASK)
                                    | (r.virt_addr & 32'h0000_0FFF);
                else
                    o.status = STS_UNMAPPED;
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    task automatic add_req(input logic [1:0] cmd, input logic [31:0] va,
                           input logic [31:0] pa, input logic [11:0] fl);
        req_t r;
        r.command = cmd;
        r.virt_addr = va;
        r.phys_addr = pa;
        r.page_flags = fl;
        req_backlog.push_back(r);
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_fire))
        begin
            if (req_gap > 0)
            begin
                req_gap <= req_gap - 1;
                req_valid <= 1'b0;
            end
            else if (req_backlog.size() > 0)
            begin
                req <= req_backlog.pop_front();
                req_valid <= 1'b1;
                if (req_calm > 0)
                begin
                    req_calm <= req_calm - 1;
                    req_gap <= 0;
                end
                else
                begin
                    req_gap <= pick_gap();
                    if ($urandom_range(0, 49) == 0)
                        req_calm <= $urandom_range(20, 60);
                end
            end
            else
                req_valid <= 1'b0;
        end
    end

    // response stall driver
    always @(negedge clk)
    begin
        int roll;
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (free_left > 0)
        begin
            free_left <= free_left - 1;
            rsp_stall <= hold_rsp;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                free_left <= $urandom_range(0, 6);
            else if (roll < 95)
                free_left <= $urandom_range(10, 30);
            else
                free_left <= $urandom_range(60, 150);
            roll = $urandom_range(0, 99);
            if (roll < 60)
                stall_left <= $urandom_range(1, 2);
            else if (roll < 90)
                stall_left <= $urandom_range(3, 6);
            else
                stall_left <= $urandom_range(15, 40);
            rsp_stall <= hold_rsp;
        end
    end

    // long receiver hold-off so the block backs up
    initial
    begin
        wait (req_count >= HOLD_AFTER);
        @(negedge clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        hold_rsp <= 1'b0;
    end

    // accepted requests feed the predictor
    always @(posedge clk)
    begin
        req_fire <= rst_n && req_valid && !req_stall;
        if (rst_n && req_valid && !req_stall)
        begin
            walk_results.push_back(page_walk(req));
            req_count <= req_count + 1;
        end
    end

    // response monitor
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_count <= rsp_count + 1;
            if (walk_results.size() == 0)
            begin
                if (fail_count < 10)
                    $display("unexpected transaction: addr=%h status=%0d",
                             rsp.result_addr, rsp.status);
                fail_count++;
            end
            else
            begin
                want = walk_results.pop_front();
                if (rsp.result_addr !== want.result_addr || rsp.status !== want.status)
                begin
                    if (fail_count < 10)
                        $display("mismatch: exp addr=%h status=%0d, got addr=%h status=%0d",
                                 want.result_addr, want.status,
                                 rsp.result_addr, rsp.status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        logic [9:0]  regions[24];
        logic [9:0]  slots[8];
        logic [31:0] va;
        logic [31:0] pa;
        logic [1:0]  cmd;
        int          roll;

        add_req(CMD_XLATE, 32'h0000_0000, 32'h0, 12'h000);
        add_req(CMD_UNMAP, 32'h0040_0000, 32'h0, 12'h000);
        add_req(CMD_MAP,   32'h0000_0ABC, 32'hFFFF_FFFF, 12'hFFF);
        add_req(CMD_XLATE, 32'h0000_0FFF, 32'h0, 12'h000);
        add_req(CMD_MAP,   32'h0000_1000, 32'h0000_0000, 12'h000);
        add_req(CMD_XLATE, 32'h0000_1123, 32'h0, 12'h000);
        add_req(CMD_XLATE, 32'h0000_2000, 32'h0, 12'h000);
        add_req(CMD_UNMAP, 32'h0000_1000, 32'h0, 12'h000);
        add_req(CMD_XLATE, 32'h0000_1000, 32'h0, 12'h000);
        add_req(CMD_UNMAP, 32'h0000_1FFF, 32'h0, 12'h000);
        add_req(CMD_XLATE, 32'h0000_1000, 32'h0, 12'h000);
        add_req(CMD_MAP,   32'hFFFF_FFFF, 32'h1234_5678, 12'h5A4);
        add_req(CMD_XLATE, 32'hFFFF_F000, 32'h0, 12'h000);
        add_req(CMD_XLATE, 32'hFFFF_EFFF, 32'h0, 12'h000);
        add_req(CMD_NOP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
        add_req(CMD_MAP,   32'h0000_0000, 32'h8000_0000, 12'h002);
        add_req(CMD_XLATE, 32'h0000_0555, 32'h0, 12'h000);
        add_req(CMD_MAP,   32'hFFC0_0000, 32'hFFFF_F000, 12'hFFE);
        add_req(CMD_XLATE, 32'hFFC0_0AAA, 32'h0, 12'h000);
        add_req(CMD_XLATE, 32'h8000_0000, 32'h0, 12'h000);

        regions[0] = 10'd0;
        regions[1] = 10'd1023;
        for (int i = 2; i < 24; i++)
            regions[i] = 10'($urandom_range(0, 1023));
        slots[0] = 10'd0;
        slots[1] = 10'd1023;
        for (int i = 2; i < 8; i++)
            slots[i] = 10'($urandom_range(0, 1023));

        for (int n = 0; n < N_RANDOM; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 35)
                cmd = CMD_MAP;
            else if (roll < 50)
                cmd = CMD_UNMAP;
            else if (roll < 95)
                cmd = CMD_XLATE;
            else
                cmd = CMD_NOP;
            va = $urandom;
            if ($urandom_range(0, 99) < 85)
            begin
                va[31:22] = regions[$urandom_range(0, 23)];
                va[21:12] = slots[$urandom_range(0, 7)];
            end
            pa = ($urandom_range(0, 19) == 0) ? 32'h0 : $urandom;
            add_req(cmd, va, pa, 12'($urandom_range(0, 4095)));
        end
        item_total = req_backlog.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (rsp_count >= item_total);
        repeat (DRAIN) @(posedge clk);
        if (fail_count == 0 && rsp_count == item_total && walk_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
